/* hw/rtl/efr_pkg.sv */
// Shared types, codes and the CRC-16 byte update for the escaped frame receiver.
// No dependencies; imported by every module of the block.
package efr_pkg;

	localparam int EFR_MAX_FRAME = 1024;

	localparam logic [15:0] EFR_POLY_RESET = 16'h8005;
	localparam logic [15:0] EFR_SEED_RESET = 16'hFFFF;

	localparam logic [7:0] EFR_START_BYTE = 8'hFD;
	localparam logic [7:0] EFR_ESC_BYTE   = 8'hFC;
	localparam logic [7:0] EFR_ESC_MASK   = 8'h80;

	// Register indexes on the configuration port
	localparam logic EFR_REG_POLY = 1'b0;
	localparam logic EFR_REG_SEED = 1'b1;

	// frame_error codes
	localparam logic [2:0] EFR_ERR_NONE     = 3'd0;
	localparam logic [2:0] EFR_ERR_CRC_HI   = 3'd1;
	localparam logic [2:0] EFR_ERR_CRC_LO   = 3'd2;
	localparam logic [2:0] EFR_ERR_SHORT    = 3'd3;
	localparam logic [2:0] EFR_ERR_OVERFLOW = 3'd4;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [9:0]  payload_index;
		logic        frame_good;
		logic [2:0]  frame_error;
		logic [15:0] frame_len_out;
		logic [7:0]  dest_out;
		logic [7:0]  counter_out;
		logic [7:0]  command_out;
	} efr_result_t;

	// MSB-first CRC-16 over one byte, eight shift steps
	function automatic logic [15:0] efr_crc_byte(input logic [15:0] crc_in,
			input logic [7:0] data, input logic [15:0] poly);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hw/rtl/escaped_frame_receiver_crc16.sv */
// Top level of the escaped frame receiver: input register, frame core, result register.
// Depends on efr_pkg, efr_cfg and efr_core.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | rx_byte
//  out     | out_valid / out_ready| payload_*, frame_*, dest/counter/command_out
//  cfg     | APB psel/penable     | paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; each accepted item passes
// through the input register, then through the frame logic into the result register.
// Reset clears the frame state to waiting, the CRC to 0xFFFF and loads register defaults.
// A stalled output holds its result; the input register takes an item while it is empty
// or while its item moves on to the result register in the same cycle.
module escaped_frame_receiver_crc16 import efr_pkg::*; #(
	parameter int MAX_FRAME = EFR_MAX_FRAME
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [9:0]  payload_index,
	output logic        frame_good,
	output logic [2:0]  frame_error,
	output logic [15:0] frame_len_out,
	output logic [7:0]  dest_out,
	output logic [7:0]  counter_out,
	output logic [7:0]  command_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        out_valid_q;
	efr_result_t res_q;
	efr_result_t res_d;
	logic        out_free;
	logic        advance;
	logic [15:0] crc_poly;
	logic [15:0] crc_init;

	efr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.crc_poly (crc_poly),
		.crc_init (crc_init)
	);

	efr_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte_s1 (rx_byte_s1),
		.crc_poly   (crc_poly),
		.crc_init   (crc_init),
		.res        (res_d)
	);

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_valid = res_q.payload_valid;
	assign payload_byte  = res_q.payload_byte;
	assign payload_index = res_q.payload_index;
	assign frame_good    = res_q.frame_good;
	assign frame_error   = res_q.frame_error;
	assign frame_len_out = res_q.frame_len_out;
	assign dest_out      = res_q.dest_out;
	assign counter_out   = res_q.counter_out;
	assign command_out   = res_q.command_out;

`ifndef NO_ASSERTIONS
	a_good_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.frame_good && (res_q.frame_error != EFR_ERR_NONE)))
		else $error("frame reported good and in error together");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.frame_error <= EFR_ERR_OVERFLOW))
		else $error("frame_error code out of range");

	a_payload_only_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.payload_valid) |->
		(!res_q.frame_good && ((res_q.frame_error == EFR_ERR_NONE) ||
		(res_q.frame_error == EFR_ERR_OVERFLOW))))
		else $error("payload byte carries an unexpected verdict");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted item missing from input register");

	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item missing from result register");
`endif

endmodule

/* hw/rtl/efr_cfg.sv */
// APB register file: CRC polynomial and CRC seed.
// Depends on efr_pkg for register indexes and reset values.
module efr_cfg import efr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] crc_poly,
	output logic [15:0] crc_init
);

	logic [15:0] poly_q;
	logic [15:0] seed_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= EFR_POLY_RESET;
			seed_q <= EFR_SEED_RESET;
		end else if (wr_en) begin
			if (paddr[2] == EFR_REG_POLY) begin
				poly_q <= pwdata[15:0];
			end else begin
				seed_q <= pwdata[15:0];
			end
		end
	end

	assign prdata   = (paddr[2] == EFR_REG_POLY) ? {16'h0000, poly_q} : {16'h0000, seed_q};
	assign crc_poly = poly_q;
	assign crc_init = seed_q;

endmodule

/* hw/rtl/efr_core.sv */
// Frame state machine: unescaping, length and payload tracking, running CRC, verdict.
// Depends on efr_pkg for codes, the result struct and the CRC byte update.
module efr_core import efr_pkg::*; #(
	parameter int MAX_FRAME = EFR_MAX_FRAME
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte_s1,
	input  logic [15:0] crc_poly,
	input  logic [15:0] crc_init,
	output efr_result_t res
);

	localparam int POS_W = $clog2(MAX_FRAME);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME - 1);

	localparam logic [2:0] PH_WAIT   = 3'd0;
	localparam logic [2:0] PH_LEN_HI = 3'd1;
	localparam logic [2:0] PH_LEN_LO = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_CRC_HI = 3'd4;
	localparam logic [2:0] PH_CRC_LO = 3'd5;

	logic [2:0]       phase_q, phase_d;
	logic             esc_q, esc_d;
	logic [15:0]      len_q, len_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       dest_q, dest_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [7:0]       cmd_q, cmd_d;

	logic [7:0]       data;
	logic [15:0]      crc_next;
	logic [POS_W-1:0] pos_inc;
	logic [16:0]      pos_inc_ext;
	logic [POS_W+9:0] pos_wide;

	assign data        = esc_q ? (rx_byte_s1 | EFR_ESC_MASK) : rx_byte_s1;
	assign crc_next    = efr_crc_byte(crc_q, data, crc_poly);
	assign pos_inc     = pos_q + 1'b1;
	assign pos_inc_ext = 17'(pos_inc);
	assign pos_wide    = {10'd0, pos_q};

	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		len_d   = len_q;
		pos_d   = pos_q;
		crc_d   = crc_q;
		dest_d  = dest_q;
		cnt_d   = cnt_q;
		cmd_d   = cmd_q;
		res     = '0;

		if (rx_byte_s1 == EFR_START_BYTE) begin
			phase_d = PH_LEN_HI;
			crc_d   = crc_init;
			esc_d   = 1'b0;
		end else if (rx_byte_s1 == EFR_ESC_BYTE) begin
			esc_d = 1'b1;
		end else begin
			esc_d = 1'b0;
			unique case (phase_q)
				PH_LEN_HI: begin
					len_d   = {data, 8'h00};
					crc_d   = crc_next;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = {len_q[15:8], data};
					crc_d   = crc_next;
					pos_d   = '0;
					phase_d = ({len_q[15:8], data} == 16'd0) ? PH_CRC_HI : PH_DATA;
				end
				PH_DATA: begin
					res.payload_valid = 1'b1;
					res.payload_byte  = data;
					res.payload_index = pos_wide[9:0];
					if (pos_q == POS_W'(0)) begin
						dest_d = data;
					end else if (pos_q == POS_W'(1)) begin
						cnt_d = data;
					end else if (pos_q == POS_W'(2)) begin
						cmd_d = data;
					end
					crc_d = crc_next;
					pos_d = pos_inc;
					if (pos_inc_ext == {1'b0, len_q}) begin
						phase_d = PH_CRC_HI;
					end else if (pos_inc >= POS_LIMIT) begin
						// payload ran past the buffer: report and drop the frame
						res.frame_error   = EFR_ERR_OVERFLOW;
						res.frame_len_out = len_q;
						phase_d           = PH_WAIT;
					end
				end
				PH_CRC_HI: begin
					if (crc_q[15:8] == data) begin
						phase_d = PH_CRC_LO;
					end else begin
						res.frame_error   = EFR_ERR_CRC_HI;
						res.frame_len_out = len_q;
						phase_d           = PH_WAIT;
					end
				end
				PH_CRC_LO: begin
					res.frame_len_out = len_q;
					if (len_q < 16'd3) begin
						res.frame_error = EFR_ERR_SHORT;
					end else if (crc_q[7:0] == data) begin
						res.frame_good  = 1'b1;
						res.dest_out    = dest_q;
						res.counter_out = cnt_q;
						res.command_out = cmd_q;
					end else begin
						res.frame_error = EFR_ERR_CRC_LO;
					end
					phase_d = PH_WAIT;
				end
				default: begin
					// waiting, or an unused code: ignore the byte
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			esc_q   <= 1'b0;
			len_q   <= '0;
			pos_q   <= '0;
			crc_q   <= EFR_SEED_RESET;
			dest_q  <= '0;
			cnt_q   <= '0;
			cmd_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			dest_q  <= dest_d;
			cnt_q   <= cnt_d;
			cmd_q   <= cmd_d;
		end
	end

endmodule

/* tb/sv/tb.sv */
// Testbench for escaped_frame_receiver_crc16: stuffed frames in, one checked result per byte.
// Depends on efr_pkg and the block's top level; prediction is built here from first principles.
`timescale 1ns / 1ps

module tb;
	import efr_pkg::*;

	localparam int unsigned FRAME_LIMIT = EFR_MAX_FRAME;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef enum logic [2:0] {
		FR_IDLE, FR_LEN_HI, FR_LEN_LO, FR_BODY, FR_CRC_HI, FR_CRC_LO
	} frame_phase_t;

	typedef enum int unsigned {
		FLAW_NONE, FLAW_CRC_HI, FLAW_CRC_LO, FLAW_CUT
	} frame_flaw_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [9:0]  payload_index;
	logic        frame_good;
	logic [2:0]  frame_error;
	logic [15:0] frame_len_out;
	logic [7:0]  dest_out;
	logic [7:0]  counter_out;
	logic [7:0]  command_out;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// mirrored registers and deframer state
	logic [15:0]  cfg_poly = EFR_POLY_RESET;
	logic [15:0]  cfg_seed = EFR_SEED_RESET;
	frame_phase_t st_phase = FR_IDLE;
	logic         st_esc = 1'b0;
	logic [15:0]  st_len = 16'h0000;
	int unsigned  st_pos = 0;
	logic [15:0]  st_crc = 16'hFFFF;
	logic [7:0]   st_dest = 8'h00;
	logic [7:0]   st_cnt = 8'h00;
	logic [7:0]   st_cmd = 8'h00;

	efr_result_t  deframed_q[$];
	logic [7:0]   frame_body[$];

	int unsigned n_fail = 0;
	int unsigned n_sent = 0;
	int unsigned n_framed = 0;
	int unsigned n_cycles = 0;
	int unsigned rx_hold = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          dbl_esc_all = 1'b0;

	escaped_frame_receiver_crc16 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_good    (frame_good),
		.frame_error   (frame_error),
		.frame_len_out (frame_len_out),
		.dest_out      (dest_out),
		.counter_out   (counter_out),
		.command_out   (command_out),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// bitwise MSB-first form of the CRC-16 byte update
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d,
			input logic [15:0] poly);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
		end
		return c;
	endfunction

	function automatic efr_result_t deframe_byte(input logic [7:0] raw);
		efr_result_t r;
		logic [7:0]  b;
		r = '0;
		b = raw;
		if (raw == EFR_START_BYTE) begin
			st_phase = FR_LEN_HI;
			st_crc = cfg_seed;
			st_esc = 1'b0;
		end else if (raw == EFR_ESC_BYTE) begin
			st_esc = 1'b1;
		end else begin
			if (st_esc) begin
				st_esc = 1'b0;
				b = b | EFR_ESC_MASK;
			end
			case (st_phase)
				FR_LEN_HI: begin
					st_len = {b, 8'h00};
					st_crc = crc16_step(st_crc, b, cfg_poly);
					st_phase = FR_LEN_LO;
				end
				FR_LEN_LO: begin
					st_len = {st_len[15:8], b};
					st_crc = crc16_step(st_crc, b, cfg_poly);
					st_pos = 0;
					st_phase = (st_len == 16'h0000) ? FR_CRC_HI : FR_BODY;
				end
				FR_BODY: begin
					r.payload_valid = 1'b1;
					r.payload_byte = b;
					r.payload_index = st_pos[9:0];
					if (st_pos == 0) st_dest = b;
					else if (st_pos == 1) st_cnt = b;
					else if (st_pos == 2) st_cmd = b;
					st_crc = crc16_step(st_crc, b, cfg_poly);
					st_pos++;
					if (st_pos == st_len) begin
						st_phase = FR_CRC_HI;
					end else if (st_pos >= FRAME_LIMIT - 1) begin
						r.frame_error = EFR_ERR_OVERFLOW;
						r.frame_len_out = st_len;
						st_phase = FR_IDLE;
					end
				end
				FR_CRC_HI: begin
					if (st_crc[15:8] == b) begin
						st_phase = FR_CRC_LO;
					end else begin
						r.frame_error = EFR_ERR_CRC_HI;
						r.frame_len_out = st_len;
						st_phase = FR_IDLE;
					end
				end
				FR_CRC_LO: begin
					r.frame_len_out = st_len;
					if (st_crc[7:0] == b && st_len >= 3) begin
						r.frame_good = 1'b1;
						r.dest_out = st_dest;
						r.counter_out = st_cnt;
						r.command_out = st_cmd;
					end else if (st_len < 3) begin
						r.frame_error = EFR_ERR_SHORT;
					end else begin
						r.frame_error = EFR_ERR_CRC_LO;
					end
					st_phase = FR_IDLE;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
			if (paddr[2] == EFR_REG_POLY) cfg_poly = pwdata[15:0];
			else cfg_seed = pwdata[15:0];
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) deframed_q.push_back(deframe_byte(rx_byte));
	end

	task automatic cmp_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			n_fail++;
			if (n_fail <= 40) $display("%0t: %s expected %0h got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		efr_result_t seen;
		efr_result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {payload_valid, payload_byte, payload_index, frame_good, frame_error,
				frame_len_out, dest_out, counter_out, command_out};
			if (deframed_q.size() == 0) begin
				n_fail++;
				if (n_fail <= 40) $display("%0t: result expected none got %h", $time, seen);
			end else begin
				want = deframed_q.pop_front();
				cmp_field("payload_valid", 32'(want.payload_valid), 32'(seen.payload_valid));
				cmp_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
				cmp_field("payload_index", 32'(want.payload_index), 32'(seen.payload_index));
				cmp_field("frame_good", 32'(want.frame_good), 32'(seen.frame_good));
				cmp_field("frame_error", 32'(want.frame_error), 32'(seen.frame_error));
				cmp_field("frame_len_out", 32'(want.frame_len_out), 32'(seen.frame_len_out));
				cmp_field("dest_out", 32'(want.dest_out), 32'(seen.dest_out));
				cmp_field("counter_out", 32'(want.counter_out), 32'(seen.counter_out));
				cmp_field("command_out", 32'(want.command_out), 32'(seen.command_out));
			end
		end
	end

	// receiver: random hold-off per result, plus one long stall on request
	initial begin : rx_side
		int unsigned gap;
		forever begin
			if (rx_hold != 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = rx_idle_on ? $urandom_range(0, 18) : 0;
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic [7:0] b);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	// escape where required, and now and then where merely allowed
	task automatic send_stuffed(input logic [7:0] b);
		if (b == EFR_START_BYTE || b == EFR_ESC_BYTE || (b[7] && $urandom_range(0, 3) == 0)) begin
			if (dbl_esc_all || $urandom_range(0, 15) == 0) send_item(EFR_ESC_BYTE);
			send_item(EFR_ESC_BYTE);
			send_item(b & ~EFR_ESC_MASK);
		end else begin
			send_item(b);
		end
	endtask

	task automatic send_frame(input logic [15:0] decl_len, input frame_flaw_t flaw);
		logic [15:0] crc;
		logic [7:0]  x;
		int unsigned stop;
		int unsigned first;
		first = n_sent;
		crc = cfg_seed;
		send_item(EFR_START_BYTE);
		send_stuffed(decl_len[15:8]);
		crc = crc16_step(crc, decl_len[15:8], cfg_poly);
		send_stuffed(decl_len[7:0]);
		crc = crc16_step(crc, decl_len[7:0], cfg_poly);
		stop = (flaw == FLAW_CUT) ? $urandom_range(0, frame_body.size()) : frame_body.size();
		for (int unsigned k = 0; k < stop; k++) begin
			send_stuffed(frame_body[k]);
			crc = crc16_step(crc, frame_body[k], cfg_poly);
		end
		if (flaw != FLAW_CUT) begin
			x = crc[15:8];
			if (flaw == FLAW_CRC_HI) x = x ^ 8'($urandom_range(1, 255));
			send_stuffed(x);
			x = crc[7:0];
			if (flaw == FLAW_CRC_LO) x = x ^ 8'($urandom_range(1, 255));
			send_stuffed(x);
		end
		n_framed += n_sent - first;
	endtask

	task automatic fill_body(input int unsigned len);
		logic [7:0] x;
		frame_body.delete();
		for (int unsigned k = 0; k < len; k++) begin
			x = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: x = EFR_START_BYTE;
					1: x = EFR_ESC_BYTE;
					2: x = 8'h00;
					default: x = 8'hFF;
				endcase
			end
			frame_body.push_back(x);
		end
	endtask

	// hold until every accepted item has produced its result
	task automatic wait_results_done;
		in_valid <= 1'b0;
		do @(posedge clk); while (deframed_q.size() != 0);
	endtask

	task automatic apb_write(input logic idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed;
		// ignored while waiting, escape included
		send_item(8'h00);
		send_item(EFR_ESC_BYTE);
		send_item(8'h7F);
		// shortest good frame, start byte as data, every escape doubled
		dbl_esc_all = 1'b1;
		frame_body.delete();
		frame_body.push_back(EFR_START_BYTE);
		frame_body.push_back(8'h00);
		frame_body.push_back(8'hFF);
		send_frame(16'd3, FLAW_NONE);
		dbl_esc_all = 1'b0;
		frame_body.delete();
		send_frame(16'd0, FLAW_NONE);
		// a start byte mid-frame restarts, then a bad CRC high byte
		send_item(EFR_START_BYTE);
		frame_body.push_back(8'h5A);
		send_frame(16'd1, FLAW_CRC_HI);
		wait_results_done();
	endtask

	task automatic run_random_frames(input int unsigned n_items);
		int unsigned goal;
		int unsigned pick;
		int unsigned len;
		frame_flaw_t flaw;
		logic [7:0]  noise;
		goal = n_framed + n_items;
		while (n_framed < goal) begin
			if ($urandom_range(0, 7) == 0) tx_idle_on = ~tx_idle_on;
			if ($urandom_range(0, 7) == 0) rx_idle_on = ~rx_idle_on;
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					noise = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 3) == 0) noise = EFR_ESC_BYTE;
					send_item(noise);
				end
			end
			pick = $urandom_range(0, 15);
			if (pick == 0) len = $urandom_range(0, 2);
			else if (pick < 12) len = $urandom_range(3, 10);
			else if (pick < 15) len = $urandom_range(11, 64);
			else len = $urandom_range(65, 200);
			fill_body(len);
			pick = $urandom_range(0, 9);
			if (pick < 7) flaw = FLAW_NONE;
			else if (pick == 7) flaw = FLAW_CRC_HI;
			else if (pick == 8) flaw = FLAW_CRC_LO;
			else flaw = FLAW_CUT;
			send_frame(16'(len), flaw);
		end
		wait_results_done();
	endtask

	task automatic run_config_sweep;
		logic [15:0] polys[4];
		logic [15:0] seeds[4];
		polys[0] = 16'h0000;
		seeds[0] = 16'h0000;
		polys[1] = 16'hFFFF;
		seeds[1] = 16'hFFFF;
		polys[2] = 16'h1021;
		seeds[2] = 16'h1D0F;
		polys[3] = 16'($urandom_range(0, 65535));
		seeds[3] = 16'($urandom_range(0, 65535));
		for (int i = 0; i < 4; i++) begin
			apb_write(EFR_REG_POLY, polys[i]);
			apb_write(EFR_REG_SEED, seeds[i]);
			run_random_frames(50);
		end
		apb_write(EFR_REG_POLY, EFR_POLY_RESET);
		apb_write(EFR_REG_SEED, EFR_SEED_RESET);
	endtask

	// long receiver stall while the sender keeps offering, so the input backs up
	task automatic run_backpressure;
		tx_idle_on = 1'b0;
		rx_hold = 300;
		fill_body(20);
		send_frame(16'd20, FLAW_NONE);
		send_frame(16'd20, FLAW_CRC_LO);
		wait_results_done();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic run_long_frames;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		// declared length beyond the frame limit: overflow on the last allowed byte
		fill_body(FRAME_LIMIT - 1);
		send_frame(16'($urandom_range(FRAME_LIMIT, 65535)), FLAW_NONE);
		wait_results_done();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= 8'h00;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'h0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random_frames(200);
		run_config_sweep();
		run_backpressure();
		run_long_frames();

		repeat (8) @(posedge clk);
		if (n_fail == 0 && deframed_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
